// ===== rtl/bnb_pkg.sv =====
// ----------------------------------------------------------------------------
// bnb_pkg
// Shared constants and types for the separable 3x3 binomial blur: pixel and
// configuration widths, register indexes, and the control groups that pass
// between the sequencer, the channel lanes and the output merge.
// ----------------------------------------------------------------------------
`default_nettype none

package bnb_pkg;

  // Sample and port geometry
  localparam int PIX_W       = 8;
  localparam int NUM_PORT_CH = 3;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int NUM_CHANNELS_DEF = 3;

  // Frame height limit and row counter width
  localparam int MAX_HEIGHT = 2048;
  localparam int ROW_W      = 11;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE  = 2'd2;

  // Register reset values
  localparam int RST_FRAME_WIDTH  = 640;
  localparam int RST_FRAME_HEIGHT = 480;

  // Border modes
  localparam logic BORDER_CROP  = 1'b0;
  localparam logic BORDER_CLAMP = 1'b1;

  // Result queue depth (power of two)
  localparam int OUT_DEPTH = 2;

  // Per-event control carried down the pipeline
  typedef struct packed {
    logic bank;       // line-store bank written by this event (row parity)
    logic older_sel;  // use the previous line in place of the older line
    logic emit_a;     // event yields the main vertical result
    logic emit_b;     // event also yields the bottom-edge clamp result
    logic line_end;   // results of this event close an output line
    logic fe_a;       // main result closes the frame
    logic fe_b;       // bottom-edge result closes the frame
  } ev_flags_t;

  // Sequencer to lane controls
  typedef struct packed {
    logic in_take;       // input request accepted this cycle
    logic left_pw1;      // left tap comes from the older window pixel
    logic ev_load_new;   // event stage loads the first horizontal result
    logic pend_load;     // pending stage loads the edge horizontal result
    logic ev_load_pend;  // event stage loads from the pending stage
    logic issue;         // line-store access, event moves to vertical stage
    logic wr_bank;       // bank written by the issuing event
    logic v_bank;        // bank that holds the older line in vertical stage
    logic older_sel;     // vertical stage uses previous line as older line
  } lane_ctl_t;

  // Sequencer to merge request
  typedef struct packed {
    logic sel_b;
    logic line_end;
    logic frame_end;
  } merge_req_t;

endpackage

`default_nettype wire

// ===== rtl/bnb_ram.sv =====
// ----------------------------------------------------------------------------
// bnb_ram
// Generic single-port RAM with registered, read-first output. The read
// register holds its value while the port is not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module bnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read old contents, then write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bnb_lane.sv =====
// ----------------------------------------------------------------------------
// bnb_lane
// One color channel: two-pixel window, horizontal 1-2-1 tap, two line-store
// banks of horizontal results, and the vertical 1-2-1 taps for the main and
// bottom-edge results.
// ----------------------------------------------------------------------------
`default_nettype none

module bnb_lane #(
  parameter int MAX_WIDTH = bnb_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  bnb_pkg::lane_ctl_t           ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic [bnb_pkg::PIX_W-1:0]    pix_in,
  output logic [bnb_pkg::PIX_W-1:0]    res_a,
  output logic [bnb_pkg::PIX_W-1:0]    res_b
);

  import bnb_pkg::*;

  function automatic logic [PIX_W-1:0] tap121(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
    logic [PIX_W+1:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    return sum[PIX_W+1:2];
  endfunction

  logic [PIX_W-1:0] pw0_r, pw1_r;
  logic [PIX_W-1:0] ev_hv_r, pend_hv_r, v_hv_r;
  logic [PIX_W-1:0] hv0, hv1;
  logic [PIX_W-1:0] rd0, rd1;
  logic [PIX_W-1:0] prev_px, old_px, older_px;

  // Horizontal taps on the incoming pixel
  assign hv0 = tap121(ctl.left_pw1 ? pw1_r : pw0_r, pw0_r, pix_in);
  assign hv1 = tap121(pw0_r, pix_in, pix_in);

  // Shift the window and hold horizontal results per stage
  always_ff @(posedge clk) begin
    if (ctl.in_take) begin
      pw1_r <= pw0_r;
      pw0_r <= pix_in;
    end
    if (ctl.ev_load_new) begin
      ev_hv_r <= hv0;
    end else if (ctl.ev_load_pend) begin
      ev_hv_r <= pend_hv_r;
    end
    if (ctl.pend_load) begin
      pend_hv_r <= hv1;
    end
    if (ctl.issue) begin
      v_hv_r <= ev_hv_r;
    end
  end

  // Line store, one bank per row parity
  bnb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_bank0 (
    .clk   (clk),
    .en    (ctl.issue),
    .we    (ctl.issue & ~ctl.wr_bank),
    .addr  (addr),
    .wdata (ev_hv_r),
    .rdata (rd0)
  );

  bnb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_bank1 (
    .clk   (clk),
    .en    (ctl.issue),
    .we    (ctl.issue & ctl.wr_bank),
    .addr  (addr),
    .wdata (ev_hv_r),
    .rdata (rd1)
  );

  // Vertical taps
  assign prev_px  = ctl.v_bank ? rd0 : rd1;
  assign old_px   = ctl.v_bank ? rd1 : rd0;
  assign older_px = ctl.older_sel ? prev_px : old_px;
  assign res_a    = tap121(older_px, prev_px, v_hv_r);
  assign res_b    = tap121(prev_px, v_hv_r, v_hv_r);

endmodule

`default_nettype wire

// ===== rtl/bnb_merge.sv =====
// ----------------------------------------------------------------------------
// bnb_merge
// Collects the lane results of one output pixel with its line and frame
// flags into a short result queue that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bnb_merge #(
  parameter int LANES = bnb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  bnb_pkg::merge_req_t                 req,
  input  logic [LANES-1:0][bnb_pkg::PIX_W-1:0] res_a,
  input  logic [LANES-1:0][bnb_pkg::PIX_W-1:0] res_b,
  output logic                                room,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bnb_pkg::PIX_W-1:0]           out_red,
  output logic [bnb_pkg::PIX_W-1:0]           out_green,
  output logic [bnb_pkg::PIX_W-1:0]           out_blue,
  output logic                                out_line_end,
  output logic                                out_frame_end
);

  import bnb_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  logic [LANES-1:0][PIX_W-1:0] q_data_r [OUT_DEPTH];
  logic                        q_le_r   [OUT_DEPTH];
  logic                        q_fe_r   [OUT_DEPTH];
  logic [PW-1:0]               wr_ptr_r, rd_ptr_r;
  logic [PW:0]                 count_r;
  logic                        pop;
  logic [LANES-1:0][PIX_W-1:0] rd_data;
  logic [NUM_PORT_CH-1:0][PIX_W-1:0] out_pix;

  assign room      = (count_r != (PW + 1)'(OUT_DEPTH));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW + 1)'(1);
      end
    end
  end

  // Store the selected result of every lane
  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[wr_ptr_r] <= req.sel_b ? res_b : res_a;
      q_le_r[wr_ptr_r]   <= req.line_end;
      q_fe_r[wr_ptr_r]   <= req.frame_end;
    end
  end

  assign rd_data = q_data_r[rd_ptr_r];

  // Channels without a lane read as zero
  for (genvar ch = 0; ch < NUM_PORT_CH; ch++) begin : g_out
    if (ch < LANES) begin : g_lane
      assign out_pix[ch] = rd_data[ch];
    end else begin : g_zero
      assign out_pix[ch] = '0;
    end
  end

  assign out_red       = out_pix[0];
  assign out_green     = out_pix[1];
  assign out_blue      = out_pix[2];
  assign out_line_end  = q_le_r[rd_ptr_r];
  assign out_frame_end = q_fe_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/separable_binomial_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// separable_binomial_blur_3x3_core
// Separable 3x3 binomial (1-2-1 by 1-2-1) blur over a raster RGB stream,
// with crop or edge-replicate borders and configurable frame size.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and, in crop mode and in all rows but
// the last of clamp mode, gives one result per clock, while the output is not
// stalled. In clamp mode the last pixel of each line stalls the input while
// its second result waits, because both of its horizontal results go through
// the same single line-store port per channel one after the other. In the
// last input row of a clamp-mode frame each horizontal result yields two
// output pixels, so that row runs at the output rate of one pixel per clock.
// Each channel lane keeps two banks of MAX_WIDTH horizontal results; they
// need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_binomial_blur_3x3_core #(
  parameter int MAX_WIDTH    = bnb_pkg::MAX_WIDTH_DEF,
  parameter int NUM_CHANNELS = bnb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bnb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bnb_pkg::CFG_W-1:0]         cfg_data,
  // Input pixels
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bnb_pkg::PIX_W-1:0]         in_red,
  input  logic [bnb_pkg::PIX_W-1:0]         in_green,
  input  logic [bnb_pkg::PIX_W-1:0]         in_blue,
  input  logic                              in_frame_start,
  // Output pixels
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bnb_pkg::PIX_W-1:0]         out_red,
  output logic [bnb_pkg::PIX_W-1:0]         out_green,
  output logic [bnb_pkg::PIX_W-1:0]         out_blue,
  output logic                              out_line_end,
  output logic                              out_frame_end
);

  import bnb_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int LANES   = (NUM_CHANNELS < NUM_PORT_CH) ? NUM_CHANNELS : NUM_PORT_CH;
  localparam int RST_W   = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int RST_WM1 = RST_W - 1;
  localparam int RST_HM1 = RST_FRAME_HEIGHT - 1;

  // Configuration, kept as last column / last row
  logic [CW-1:0]    wm1_r;
  logic [ROW_W-1:0] hm1_r;
  logic             clamp_r;
  logic [CW-1:0]    wm1_nxt;
  logic [ROW_W-1:0] hm1_nxt;
  int               w_val, h_val;

  // Position counters
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_n;
  logic [ROW_W-1:0] row_n;
  logic             col_ge1, col_ge2, col_last;
  logic             row_ge1, row_ge2, row_last;

  // Event stages
  logic             ev_valid_r, pend_valid_r, v_valid_r, phase_r;
  logic [CW-1:0]    ev_x_r, pend_x_r;
  ev_flags_t        ev_flags_r, pend_flags_r, v_flags_r;
  logic             ev0_valid, ev1_valid;
  logic [CW-1:0]    ev0_x;
  ev_flags_t        ev0_flags, ev1_flags;

  // Handshake and pipeline control
  logic             in_take, fifo_room, push, v_last, v_done, v_free;
  logic             issue, ev_free, pend_move;
  lane_ctl_t        lane_ctl;
  merge_req_t       mreq;

  logic [NUM_PORT_CH-1:0][PIX_W-1:0] in_pix;
  logic [LANES-1:0][PIX_W-1:0]       res_a, res_b;

  assign cfg_ready = 1'b1;

  // Saturate sizes on write
  always_comb begin
    w_val = int'(cfg_data);
    if (w_val < 3) begin
      w_val = 3;
    end else if (w_val > MAX_WIDTH) begin
      w_val = MAX_WIDTH;
    end
    h_val = int'(cfg_data);
    if (h_val < 3) begin
      h_val = 3;
    end else if (h_val > MAX_HEIGHT) begin
      h_val = MAX_HEIGHT;
    end
    wm1_nxt = CW'(w_val - 1);
    hm1_nxt = ROW_W'(h_val - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r   <= CW'(RST_WM1);
      hm1_r   <= ROW_W'(RST_HM1);
      clamp_r <= BORDER_CROP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  wm1_r   <= wm1_nxt;
        CFG_FRAME_HEIGHT: hm1_r   <= hm1_nxt;
        CFG_BORDER_MODE:  clamp_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Current pixel position
  always_comb begin
    col_n = col_r;
    row_n = row_r;
    if (in_frame_start || col_r > wm1_r) begin
      col_n = '0;
    end
    if (in_frame_start || row_r > hm1_r) begin
      row_n = '0;
    end
  end

  assign col_ge1  = (col_n != '0);
  assign col_ge2  = (col_n[CW-1:1] != '0);
  assign col_last = (col_n == wm1_r);
  assign row_ge1  = (row_n != '0);
  assign row_ge2  = (row_n[ROW_W-1:1] != '0);
  assign row_last = (row_n == hm1_r);

  // Horizontal results this pixel makes available
  always_comb begin
    ev0_valid           = col_ge1;
    ev0_x               = col_n - CW'(1);
    ev0_flags.bank      = row_n[0];
    ev0_flags.older_sel = ~row_ge2;
    ev1_valid           = (clamp_r == BORDER_CLAMP) && col_last && col_ge1;
    ev1_flags.bank      = row_n[0];
    ev1_flags.older_sel = ~row_ge2;
    ev1_flags.emit_a    = row_ge1;
    ev1_flags.emit_b    = row_last;
    ev1_flags.line_end  = 1'b1;
    ev1_flags.fe_a      = 1'b0;
    ev1_flags.fe_b      = 1'b1;
    if (clamp_r == BORDER_CLAMP) begin
      ev0_flags.emit_a   = row_ge1;
      ev0_flags.emit_b   = row_last;
      ev0_flags.line_end = 1'b0;
      ev0_flags.fe_a     = 1'b0;
      ev0_flags.fe_b     = 1'b0;
    end else begin
      ev0_flags.emit_a   = row_ge2 & col_ge2;
      ev0_flags.emit_b   = 1'b0;
      ev0_flags.line_end = col_last;
      ev0_flags.fe_a     = col_last & row_last;
      ev0_flags.fe_b     = 1'b0;
    end
  end

  // Vertical stage drains one result a cycle while the queue has room; event stage follows it
  assign push      = v_valid_r & (phase_r | v_flags_r.emit_a) & fifo_room;
  assign v_last    = phase_r | ~v_flags_r.emit_b;
  assign v_done    = v_valid_r & (~v_flags_r.emit_a | (fifo_room & v_last));
  assign v_free    = ~v_valid_r | v_done;
  assign issue     = ev_valid_r & v_free;
  assign ev_free   = ~ev_valid_r | issue;
  assign pend_move = pend_valid_r & ev_free;
  assign in_stall  = ~ev_free | pend_valid_r;
  assign in_take   = in_valid & ~in_stall;

  // Advance position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_take) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_n + ROW_W'(1);
      end else begin
        col_r <= col_n + CW'(1);
        row_r <= row_n;
      end
    end
  end

  // Stage valids and result phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      v_valid_r    <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      if (in_take) begin
        ev_valid_r <= ev0_valid;
      end else if (pend_move) begin
        ev_valid_r <= 1'b1;
      end else if (issue) begin
        ev_valid_r <= 1'b0;
      end
      if (in_take) begin
        pend_valid_r <= ev1_valid;
      end else if (pend_move) begin
        pend_valid_r <= 1'b0;
      end
      if (issue) begin
        v_valid_r <= 1'b1;
      end else if (v_done) begin
        v_valid_r <= 1'b0;
      end
      if (v_done) begin
        phase_r <= 1'b0;
      end else if (push) begin
        phase_r <= 1'b1;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_x_r       <= ev0_x;
      ev_flags_r   <= ev0_flags;
      pend_x_r     <= col_n;
      pend_flags_r <= ev1_flags;
    end else if (pend_move) begin
      ev_x_r     <= pend_x_r;
      ev_flags_r <= pend_flags_r;
    end
    if (issue) begin
      v_flags_r <= ev_flags_r;
    end
  end

  // Lane controls
  always_comb begin
    lane_ctl.in_take      = in_take;
    lane_ctl.left_pw1     = col_ge2;
    lane_ctl.ev_load_new  = in_take & ev0_valid;
    lane_ctl.pend_load    = in_take & ev1_valid;
    lane_ctl.ev_load_pend = pend_move;
    lane_ctl.issue        = issue;
    lane_ctl.wr_bank      = ev_flags_r.bank;
    lane_ctl.v_bank       = v_flags_r.bank;
    lane_ctl.older_sel    = v_flags_r.older_sel;
  end

  assign in_pix = {in_blue, in_green, in_red};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bnb_lane #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .addr   (ev_x_r),
      .pix_in (in_pix[i]),
      .res_a  (res_a[i]),
      .res_b  (res_b[i])
    );
  end

  // Merge request for the result being pushed
  always_comb begin
    mreq.sel_b     = phase_r;
    mreq.line_end  = v_flags_r.line_end;
    mreq.frame_end = phase_r ? v_flags_r.fe_b : v_flags_r.fe_a;
  end

  bnb_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .req           (mreq),
    .res_a         (res_a),
    .res_b         (res_b),
    .room          (fifo_room),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/bnb_checker.sv =====
// ----------------------------------------------------------------------------
// bnb_checker
// Port-level checks for the blur core: output hold under stall, flag
// consistency, and the state of both channels after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bnb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [bnb_pkg::PIX_W-1:0] out_red,
  input logic [bnb_pkg::PIX_W-1:0] out_green,
  input logic [bnb_pkg::PIX_W-1:0] out_blue,
  input logic                      out_line_end,
  input logic                      out_frame_end
);

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_line_end, out_frame_end}))
    else $error("stalled output request changed");

  // Frame end only on a line end
  a_fe_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_line_end)
    else $error("frame end without line end");

  // Reset drops queued results
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset opens the input
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind separable_binomial_blur_3x3_core bnb_checker u_bnb_checker (.*);

`default_nettype wire

// ===== verif/blur_checker.sv =====
// ----------------------------------------------------------------------------
// blur_checker
// Watches the configuration, pixel and result channels of the 3x3 binomial
// blur. Keeps its own copy of the frame geometry, pixel window and line
// store, works out the blurred pixels that each accepted request causes, and
// compares every accepted result with the oldest one still expected.
// ----------------------------------------------------------------------------
module blur_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bnb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bnb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bnb_pkg::PIX_W-1:0]     in_red,
  input  logic [bnb_pkg::PIX_W-1:0]     in_green,
  input  logic [bnb_pkg::PIX_W-1:0]     in_blue,
  input  logic                          in_frame_start,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bnb_pkg::PIX_W-1:0]     out_red,
  input  logic [bnb_pkg::PIX_W-1:0]     out_green,
  input  logic [bnb_pkg::PIX_W-1:0]     out_blue,
  input  logic                          out_line_end,
  input  logic                          out_frame_end,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bnb_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t px;
    logic line_end;
    logic frame_end;
  } blurred_t;

  // Horizontal results of the two most recent lines, one bank per row parity
  rgb_t             hline_mem [2][MAX_W];
  rgb_t             win_last;
  rgb_t             win_older;
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             border_reg;
  blurred_t         blurred_q [$];
  int               fail_cnt  = 0;
  int               result_no = 0;

  function automatic int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // (a + 2b + c) / 4, truncated
  function automatic logic [PIX_W-1:0] tap121(logic [PIX_W-1:0] a, b, c);
    logic [PIX_W+1:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    return sum[PIX_W+1:2];
  endfunction

  function automatic rgb_t blur3(rgb_t a, rgb_t b, rgb_t c);
    rgb_t v;
    v.r = tap121(a.r, b.r, c.r);
    v.g = tap121(a.g, b.g, c.g);
    v.b = tap121(a.b, b.b, c.b);
    return v;
  endfunction

  task automatic expect_px(input rgb_t v, input logic le, input logic fe);
    blurred_t res;
    res.px        = v;
    res.line_end  = le;
    res.frame_end = fe;
    blurred_q.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Work out the blurred pixels caused by one input pixel and advance
  task automatic filter_pixel(input rgb_t cur, input logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    int unsigned x;
    int unsigned nev;
    int unsigned hx [2];
    rgb_t        hv [2];
    rgb_t        prev;
    rgb_t        older;
    logic        le;
    w   = fit_size(width_reg, MAX_W);
    h   = fit_size(height_reg, MAX_HEIGHT);
    col = col_cnt;
    row = row_cnt;
    if (fs) begin
      col = 0;
      row = 0;
    end
    // a counter left beyond a shrunk size restarts at zero
    if (col >= w) col = 0;
    if (row >= h) row = 0;

    // horizontal results completed by this pixel
    nev = 0;
    if (col >= 1) begin
      hx[0] = col - 1;
      hv[0] = blur3((col >= 2) ? win_older : win_last, win_last, cur);
      nev   = 1;
      if (col == w - 1 && border_reg == BORDER_CLAMP) begin
        hx[1] = col;
        hv[1] = blur3(win_last, cur, cur);
        nev   = 2;
      end
    end

    // vertical pass against the two stored lines
    for (int e = 0; e < nev; e++) begin
      x     = hx[e];
      prev  = hline_mem[(row + 1) % 2][x];
      older = (row >= 2) ? hline_mem[row % 2][x] : prev;
      if (border_reg == BORDER_CROP) begin
        if (row >= 2 && x >= 1 && x <= w - 2) begin
          le = (x == w - 2);
          expect_px(blur3(older, prev, hv[e]), le, le && row == h - 1);
        end
      end else if (row >= 1) begin
        le = (x == w - 1);
        expect_px(blur3(older, prev, hv[e]), le, 1'b0);
        // bottom edge replicated: last input row closes two output rows
        if (row == h - 1) expect_px(blur3(prev, hv[e], hv[e]), le, le);
      end
      hline_mem[row % 2][x] = hv[e];
    end

    win_older = win_last;
    win_last  = cur;

    // advance raster position, wrapping at line and frame ends
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  always @(posedge clk) begin : track
    blurred_t want;
    if (!rst_n) begin
      width_reg  = CFG_W'(RST_FRAME_WIDTH);
      height_reg = CFG_W'(RST_FRAME_HEIGHT);
      border_reg = BORDER_CROP;
      col_cnt    = 0;
      row_cnt    = 0;
      win_last   = '0;
      win_older  = '0;
      blurred_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_reg  = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          CFG_BORDER_MODE:  border_reg = cfg_data[0];
          default: ;
        endcase
      end

      // predict from each accepted pixel request
      if (in_valid && !in_stall) filter_pixel({in_red, in_green, in_blue}, in_frame_start);

      // compare each accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
          want = blurred_q.pop_front();
          if (out_red !== want.px.r)
            report_mismatch($sformatf("result %0d red: got %0d expected %0d",
                                      result_no, out_red, want.px.r));
          if (out_green !== want.px.g)
            report_mismatch($sformatf("result %0d green: got %0d expected %0d",
                                      result_no, out_green, want.px.g));
          if (out_blue !== want.px.b)
            report_mismatch($sformatf("result %0d blue: got %0d expected %0d",
                                      result_no, out_blue, want.px.b));
          if (out_line_end !== want.line_end)
            report_mismatch($sformatf("result %0d line_end: got %b expected %b",
                                      result_no, out_line_end, want.line_end));
          if (out_frame_end !== want.frame_end)
            report_mismatch($sformatf("result %0d frame_end: got %b expected %b",
                                      result_no, out_frame_end, want.frame_end));
        end
        result_no++;
      end
    end
    pending    <= blurred_q.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the 3x3 binomial blur with directed extreme frames, mid-frame
// resizes, a long output hold-off, saturated frame sizes and random frames of
// random geometry and border mode, under three idling schemes. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bnb_pkg::*;

  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int RANDOM_ITEMS    = 60;
  localparam int SAT_ITEMS       = 24;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_red         = '0;
  logic [PIX_W-1:0]     in_green       = '0;
  logic [PIX_W-1:0]     in_blue        = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 out_line_end;
  logic                 out_frame_end;

  int          mismatches;
  int          pending;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          hold_reqs    = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;
  int          sent         = 0;
  int unsigned eff_w        = RST_FRAME_WIDTH;
  int unsigned eff_h        = RST_FRAME_HEIGHT;
  int unsigned s_col        = 0;
  int unsigned s_row        = 0;

  separable_binomial_blur_3x3_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_line_end   (out_line_end),
    .out_frame_end  (out_frame_end)
  );

  blur_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_line_end   (out_line_end),
    .out_frame_end  (out_frame_end),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always #6 clk = ~clk;

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("no request accepted for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel request, idling first at random, and track its position
  task automatic send_px(input logic [PIX_W-1:0] r, g, b, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    if (fs) begin
      s_col = 0;
      s_row = 0;
    end
    if (s_col >= eff_w) s_col = 0;
    if (s_row >= eff_h) s_row = 0;
    if (s_col + 1 >= eff_w) begin
      s_col = 0;
      s_row = (s_row + 1 >= eff_h) ? 0 : s_row + 1;
    end else begin
      s_col++;
    end
    sent++;
  endtask

  task automatic send_rand(input logic fs);
    send_px(rand_sample(), rand_sample(), rand_sample(), fs);
  endtask

  // Hold the sender until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Drain, then let any work that causes no result finish
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, h, input logic mode);
    reg_write(CFG_FRAME_WIDTH, w);
    reg_write(CFG_FRAME_HEIGHT, h);
    reg_write(CFG_BORDER_MODE, {{(CFG_W-1){1'b0}}, mode});
    cfg_valid <= 1'b0;
    eff_w = fit_size(w, MAX_WIDTH_DEF);
    eff_h = fit_size(h, MAX_HEIGHT);
  endtask

  // Send npx random pixels; start a frame unless already at its top,
  // sometimes leaning on the wrap instead of frame_start
  task automatic send_frame(input int npx, input bit noisy);
    logic fs;
    for (int i = 0; i < npx; i++) begin
      if (i == 0) fs = (s_col != 0 || s_row != 0 || $urandom_range(2) != 0);
      else        fs = noisy && ($urandom_range(63) == 0);
      send_rand(fs);
      if (noisy && $urandom_range(99) == 0) drain();
    end
  endtask

  // Random geometry, mode and frame shapes until n_items more are sent
  task automatic random_frames(input int n_items);
    int          stop;
    int unsigned w;
    int unsigned h;
    stop = sent + n_items;
    while (sent < stop) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
      h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      settle();
      set_frame(CFG_W'(w), CFG_W'(h), $urandom_range(1) ? BORDER_CLAMP : BORDER_CROP);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(5))
          0:       send_frame($urandom_range(1, eff_w * eff_h - 1), 1'b1);
          1:       send_frame(eff_w * eff_h, 1'b1);
          default: send_frame(eff_w * eff_h, 1'b0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct = 26;
    rx_idle_pct <= 55;
    @(posedge clk);

    // clamp on the smallest frame, width below range: four results at the end
    set_frame(CFG_W'(1), CFG_W'(3), BORDER_CLAMP);
    for (int i = 0; i < 9; i++)
      send_px(i[0] ? '1 : '0, (i % 3 == 0) ? '1 : '0, (i >= 4) ? '1 : '0, i == 0);

    // crop on the smallest frame, height below range: a single interior pixel
    settle();
    set_frame(CFG_W'(3), CFG_W'(2), BORDER_CROP);
    for (int i = 0; i < 9; i++)
      send_px((i == 4) ? '0 : '1, '1, (i == 2) ? '0 : '1, i == 0);
    // next frame starts by wrapping, without frame_start
    repeat (9) send_rand(1'b0);

    // shrink the width mid-frame: column beyond the new width restarts
    settle();
    set_frame(CFG_W'(6), CFG_W'(5), BORDER_CROP);
    send_rand(1'b1);
    repeat (16) send_rand(1'b0);
    settle();
    set_frame(CFG_W'(4), CFG_W'(5), BORDER_CROP);
    repeat (12) send_rand(1'b0);

    // shrink the height mid-frame: row beyond the new height restarts
    settle();
    set_frame(CFG_W'(4), CFG_W'(6), BORDER_CLAMP);
    send_rand(1'b1);
    repeat (17) send_rand(1'b0);
    settle();
    set_frame(CFG_W'(4), CFG_W'(3), BORDER_CLAMP);
    repeat (10) send_rand(1'b0);

    random_frames(RANDOM_ITEMS);

    // swap idling between the two sides
    tx_idle_pct = 55;
    rx_idle_pct <= 26;
    random_frames(RANDOM_ITEMS);

    // long output hold-off while pixels keep coming, then a mid-frame drain
    settle();
    tx_idle_pct = 0;
    set_frame(CFG_W'(8), CFG_W'(4), BORDER_CROP);
    send_frame(16, 1'b0);
    hold_reqs <= hold_reqs + 1;
    send_frame(16, 1'b0);
    send_frame(18, 1'b0);
    drain();
    send_frame(14, 1'b0);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_frames(RANDOM_ITEMS);

    // saturated sizes: open a frame at the widest size in clamp, tallest in crop
    settle();
    set_frame('1, CFG_W'(3), BORDER_CLAMP);
    send_frame(SAT_ITEMS, 1'b0);
    settle();
    set_frame('0, '1, BORDER_CROP);
    send_frame(SAT_ITEMS, 1'b0);

    settle();
    if (pending != 0) $display("%0d blurred pixels never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
